FILE: rtl/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and codes for the stable sorted priority queue core.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int ValueW = 32;
  localparam int PrioW  = 32;
  localparam int OccW   = 5;

  // Operation codes carried on in_tuser.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Result status codes carried on out_tuser.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } item_t;

  // Broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic  enq;
    logic  deq;
    item_t new_item;
  } cell_ctrl_t;

endpackage

FILE: rtl/stable_sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// Bounded priority queue kept sorted by descending priority in a chain of
// slot cells; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata (low bit up)                    tuser
//  in_      slave      value[31:0], priority[63:32]          func
//  out_     master     value, priority, occupancy[68:64]     status
//
//  Every cell compares its priority with the broadcast newcomer in parallel,
//  so one transfer per cycle is taken while in_tready is high.
//  The result sits in an output register; a new input transfer is taken while
//  out_tready is high or the register is empty.
//  Reset (rst_n low, synchronous) empties the queue and drops any result.
//  Slot contents are not cleared; only the entry count and output valid are reset.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_core import ssq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // item_value[31:0], item_priority[63:32]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_value[31:0], out_priority[63:32],
                                  // occupancy[68:64], zero fill
  output logic [1:0]  out_tuser   // status
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  item_t         res_r, res_nxt;
  logic [OccW-1:0] occ_r;

  cell_ctrl_t ctrl;
  item_t      cell_items [CAPACITY];
  logic       cell_ge    [CAPACITY];

  logic acc, full, empty, is_enq;
  logic [CW+OccW-1:0] occ_wide;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign is_enq    = (in_tuser == FUNC_ENQ);
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);

  assign ctrl.enq              = acc && is_enq && !full;
  assign ctrl.deq              = acc && !is_enq && !empty;
  assign ctrl.new_item.value   = in_tdata[31:0];
  assign ctrl.new_item.prio    = in_tdata[63:32];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      item_t left_item, right_item;
      logic  left_ge;
      if (gi == 0) begin : g_head
        assign left_item = cell_items[0];
        assign left_ge   = 1'b1;
      end else begin : g_mid
        assign left_item = cell_items[gi-1];
        assign left_ge   = cell_ge[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign right_item = cell_items[gi];
      end else begin : g_body
        assign right_item = cell_items[gi+1];
      end
      ssq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (count_r > CW'(gi)),
        .left_ge    (left_ge),
        .left_item  (left_item),
        .right_item (right_item),
        .item       (cell_items[gi]),
        .ge         (cell_ge[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt    = count_r;
    status_nxt   = ST_OK;
    res_nxt      = '0;
    priority if (ctrl.enq) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.deq) begin
      count_nxt = count_r - CW'(1);
      res_nxt   = cell_items[0];
    end else if (is_enq) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_EMPTY;
    end
  end

  assign occ_wide = (CW+OccW)'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (acc) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      occ_r    <= occ_wide[OccW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, occ_r, res_r.prio, res_r.value};

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A successful insert grows the queue by exactly one.
  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.enq |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the queue by one");

  // The two front slots stay in descending priority order.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CW'(2) |-> !(cell_items[0].prio < cell_items[1].prio))
    else $error("head slots out of order");

  // A refused dequeue reports an empty queue and no data.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_EMPTY |-> occ_r == '0 && res_r == '0)
    else $error("empty status with nonzero payload");

endmodule

FILE: rtl/ssq_cell.sv
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted chain: keeps its entry, takes the new entry, or
// takes a neighbor's entry, depending on the broadcast operation.
// ----------------------------------------------------------------------------
module ssq_cell import ssq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,        // this slot holds a live entry
  input  logic       left_ge,    // left neighbor stays put on an insert
  input  item_t      left_item,
  input  item_t      right_item,
  output item_t      item,
  output logic       ge
);

  item_t item_r;
  item_t item_nxt;

  // An entry of equal priority stays ahead of the newcomer.
  assign ge   = occ && !(item_r.prio < ctrl.new_item.prio);
  assign item = item_r;

  always_comb begin
    item_nxt = item_r;
    priority if (ctrl.enq) begin
      priority if (ge) begin
        item_nxt = item_r;
      end else if (left_ge) begin
        item_nxt = ctrl.new_item;
      end else begin
        item_nxt = left_item;
      end
    end else if (ctrl.deq) begin
      item_nxt = right_item;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stable sorted priority queue core. A short
// directed sequence covers the field extremes, equal priorities, an empty
// dequeue and a refused enqueue into a full queue. It is followed by random
// operations in phases that lean toward filling, balancing or draining the queue. Every
// result transfer is compared against a bit-accurate queue predictor.
// ----------------------------------------------------------------------------
module testbench;
  import ssq_pkg::*;

  localparam int CAP       = 16;
  localparam int RANDOM_N  = 2000;
  localparam int SETTLE    = 10;

  typedef struct {
    logic                     func;
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } queue_op_t;

  typedef struct {
    logic [1:0]               status;
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
    logic [OccW-1:0]          occ;
  } queue_resp_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        in_tuser   = FUNC_ENQ;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  stable_sorted_priority_queue_core #(.CAPACITY(CAP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  // Shadow copy of the queue contents, sorted by descending priority.
  logic signed [ValueW-1:0] shadow_value [CAP];
  logic signed [PrioW-1:0]  shadow_prio  [CAP];
  int                       shadow_count = 0;

  queue_op_t   op_backlog[$];
  queue_resp_t due_responses[$];
  int          ops_total   = 0;
  int          ops_sent    = 0;
  int          errors      = 0;
  int          n_enq_ok    = 0;
  int          n_full      = 0;
  int          n_empty     = 0;
  int          n_deq_ok    = 0;
  int          peak_occ    = 0;

  function automatic queue_resp_t apply_queue_op(queue_op_t op);
    queue_resp_t r;
    int          pos;
    int          i;
    r.status = ST_OK;
    r.value  = '0;
    r.prio   = '0;
    if (op.func == FUNC_ENQ) begin
      if (shadow_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        // A newcomer goes behind every held entry of equal or higher priority.
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= op.prio) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_value[i] = shadow_value[i-1];
          shadow_prio[i]  = shadow_prio[i-1];
        end
        shadow_value[pos] = op.value;
        shadow_prio[pos]  = op.prio;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value = shadow_value[0];
        r.prio  = shadow_prio[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_value[i-1] = shadow_value[i];
          shadow_prio[i-1]  = shadow_prio[i];
        end
        shadow_count--;
      end
    end
    r.occ = shadow_count[OccW-1:0];
    return r;
  endfunction

  function automatic queue_op_t make_op(logic func, logic [31:0] value, logic [31:0] prio);
    queue_op_t op;
    op.func  = func;
    op.value = value;
    op.prio  = prio;
    return op;
  endfunction

  // Mostly narrow priorities so that ties are common, plus wide and extreme ones.
  function automatic logic [31:0] random_prio();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 32'($signed($urandom_range(0, 6)) - 3);
    if (sel < 8) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents items in bursts with random gaps and runs the predictor
  // on every accepted transfer.
  // --------------------------------------------------------------------------
  queue_op_t cur_op;
  int        burst_left = 1;
  int        gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        // Successful enqueues and dequeues are counted before the shadow moves.
        if (cur_op.func == FUNC_ENQ && shadow_count < CAP) n_enq_ok++;
        if (cur_op.func == FUNC_DEQ && shadow_count > 0) n_deq_ok++;
        due_responses.push_back(apply_queue_op(cur_op));
        ops_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (op_backlog.size() > 0) begin
          cur_op = op_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_op.func;
          in_tdata  <= {cur_op.prio, cur_op.value};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver ready pattern: changing stall modes, rare long hold-offs, and one
  // forced hold-off early in the random phase so the input side backs up.
  // --------------------------------------------------------------------------
  int stall_mode  = 0;
  int mode_left   = 0;
  int hold_left   = 0;
  bit forced_hold = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (!forced_hold && ops_sent >= 250) begin
        forced_hold = 1'b1;
        hold_left   = 80;
      end else if (hold_left == 0 && $urandom_range(0, 999) < 3) begin
        hold_left = $urandom_range(30, 70);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compares each result transfer with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_responses.size() == 0) begin
        $display("%0t: result transfer with nothing predicted: status %0d data %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = due_responses.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_tuser);
          errors++;
        end
        if (out_tdata[31:0] !== want.value) begin
          $display("%0t: value expected %h, got %h", $time, want.value, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== want.prio) begin
          $display("%0t: priority expected %h, got %h", $time, want.prio, out_tdata[63:32]);
          errors++;
        end
        if (out_tdata[68:64] !== want.occ) begin
          $display("%0t: occupancy expected %0d, got %0d", $time, want.occ,
                   out_tdata[68:64]);
          errors++;
        end
        case (want.status)
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          default: begin
            if (want.occ > peak_occ) peak_occ = want.occ;
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int k;
    int phase_left;
    int enq_weight;

    // Directed: empty dequeue, extremes, ties, a full refusal, then a few heads.
    op_backlog.push_back(make_op(FUNC_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    op_backlog.push_back(make_op(FUNC_ENQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    op_backlog.push_back(make_op(FUNC_ENQ, 32'h8000_0000, 32'h8000_0000));
    op_backlog.push_back(make_op(FUNC_ENQ, 32'h0000_0000, 32'h0000_0000));
    op_backlog.push_back(make_op(FUNC_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    op_backlog.push_back(make_op(FUNC_ENQ, 32'h0000_000A, 32'h7FFF_FFFF));
    op_backlog.push_back(make_op(FUNC_ENQ, 32'h0000_000B, 32'h8000_0000));
    for (k = 0; k < 10; k++)
      op_backlog.push_back(make_op(FUNC_ENQ, 32'h100 + k, (k % 2) ? 32'd5 : 32'hFFFF_FFFF));
    op_backlog.push_back(make_op(FUNC_ENQ, 32'h5555_AAAA, 32'h7FFF_FFFF));
    for (k = 0; k < 5; k++)
      op_backlog.push_back(make_op(FUNC_DEQ, $urandom, $urandom));

    // Random: phases that lean toward filling, balancing or draining.
    phase_left = 0;
    enq_weight = 50;
    for (k = 0; k < RANDOM_N; k++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       enq_weight = 85;
          1:       enq_weight = 50;
          default: enq_weight = 15;
        endcase
      end
      phase_left--;
      if ($urandom_range(1, 100) <= enq_weight)
        op_backlog.push_back(make_op(FUNC_ENQ, $urandom, random_prio()));
      else
        op_backlog.push_back(make_op(FUNC_DEQ, $urandom, $urandom));
    end
    ops_total = op_backlog.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_sent < ops_total || due_responses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d operations: %0d enqueues stored, %0d refused as full,",
             ops_total, n_enq_ok, n_full);
    $display("%0d heads removed, %0d empty dequeues, peak occupancy %0d.",
             n_deq_ok, n_empty, peak_occ);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d of %0d operations sent, %0d results outstanding",
             ops_sent, ops_total, due_responses.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ssq_pkg.sv
rtl/ssq_cell.sv
rtl/stable_sorted_priority_queue_core.sv
tb/testbench.sv
